@@ design/fdtsp_pkg.sv @@
// Shared types, token codes and result codes of the structure-block token parser.
package fdtsp_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int WORD_W    = 32;
    localparam int LEFT_W    = WORD_W - 1;
    localparam int KIND_W    = 4;
    localparam int ERR_W     = 3;
    localparam int QDEPTH    = 2;

    localparam logic [WORD_W-1:0] TOKEN_BEGIN   = 32'h0000_0001;
    localparam logic [WORD_W-1:0] TOKEN_ENDNODE = 32'h0000_0002;
    localparam logic [WORD_W-1:0] TOKEN_PROP    = 32'h0000_0003;
    localparam logic [WORD_W-1:0] TOKEN_NOP     = 32'h0000_0004;
    localparam logic [WORD_W-1:0] TOKEN_END     = 32'h0000_0009;

    typedef logic [2:0] tok_cls_t;
    localparam tok_cls_t CLS_BEGIN   = 3'd0;
    localparam tok_cls_t CLS_ENDNODE = 3'd1;
    localparam tok_cls_t CLS_PROP    = 3'd2;
    localparam tok_cls_t CLS_NOP     = 3'd3;
    localparam tok_cls_t CLS_END     = 3'd4;
    localparam tok_cls_t CLS_UNKNOWN = 3'd5;

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t K_BEGIN   = 4'd0;
    localparam kind_t K_NAME    = 4'd1;
    localparam kind_t K_PROP    = 4'd2;
    localparam kind_t K_LEN     = 4'd3;
    localparam kind_t K_NAMEOFF = 4'd4;
    localparam kind_t K_VALUE   = 4'd5;
    localparam kind_t K_ENDNODE = 4'd6;
    localparam kind_t K_NOP     = 4'd7;
    localparam kind_t K_END     = 4'd8;
    localparam kind_t K_ERROR   = 4'd9;

    typedef logic [ERR_W-1:0] err_t;
    localparam err_t E_NONE      = 3'd0;
    localparam err_t E_UNKNOWN   = 3'd1;
    localparam err_t E_STRUCT    = 3'd2;
    localparam err_t E_DEPTH     = 3'd3;
    localparam err_t E_AFTER_END = 3'd4;

    // One predecoded word as it sits in the queue.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        tok_cls_t          cls;
        logic              zero_byte;
        logic [LEFT_W-1:0] len_words;
    } pre_t;

    typedef struct packed {
        logic valid;
        pre_t data;
    } push_t;

endpackage

@@ design/fdtsp_if.sv @@
// Word and result channel interfaces with valid/ready handshake.
interface fdtsp_word_if;
    logic                          valid;
    logic                          ready;
    logic [fdtsp_pkg::WORD_W-1:0]  word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface fdtsp_result_if;
    logic                          valid;
    logic                          ready;
    logic [fdtsp_pkg::KIND_W-1:0]  kind;
    logic [fdtsp_pkg::DEPTH_W-1:0] depth;
    logic [fdtsp_pkg::WORD_W-1:0]  field_value;
    logic [fdtsp_pkg::ERR_W-1:0]   error_code;

    modport source (output valid, output kind, output depth, output field_value,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input depth, input field_value,
                    input error_code, output ready);
endinterface

@@ design/fdt_structure_token_parser.sv @@
// Top level of the structure-block token parser.
//
// Channels: words carries one 32-bit structure-block word per handshake, first
// byte in bits 31..24, starting at the first word of the block. results carries
// exactly one labeled word back per input word, in order: kind, nesting depth
// after the word, field_value (the word, which is the length or name offset on
// those words) and error_code, which is nonzero only on error words.
// Both channels move a word at a clock edge where valid and ready are high.
// An accepted word passes through the queue and then the result register on its
// way to results. Throughput: one word per cycle while results.ready stays high;
// the sequencer updates phase and depth for every word that it pops.
// A two-entry queue sits between the predecoder and the sequencer. When the
// receiver stalls, the result register holds, the queue fills, and words.ready
// drops after two more words.
// Reset clears the queue, the phase, depth and sticky error, and drops
// results.valid. Once an error is raised every later word comes back as an
// error word with the stored code until the next reset.
module fdt_structure_token_parser
(
    input  logic            clk,
    input  logic            rst_n,
    fdtsp_word_if.sink      words,
    fdtsp_result_if.source  results
);

    fdtsp_pkg::push_t push;
    fdtsp_pkg::pre_t  q_data;
    logic             q_full;
    logic             q_valid;
    logic             pop;

    fdtsp_front u_front
    (
        .words  (words),
        .q_full (q_full),
        .push   (push)
    );

    fdtsp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop)
    );

    fdtsp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .results (results)
    );

endmodule

@@ design/fdtsp_front.sv @@
// Front end: accepts words and predecodes token class, zero byte and value length.
module fdtsp_front
(
    fdtsp_word_if.sink          words,
    input  logic                q_full,
    output fdtsp_pkg::push_t    push
);

    fdtsp_pkg::tok_cls_t cls;

    always_comb
    begin
        unique case (words.word)
            fdtsp_pkg::TOKEN_BEGIN:   cls = fdtsp_pkg::CLS_BEGIN;
            fdtsp_pkg::TOKEN_ENDNODE: cls = fdtsp_pkg::CLS_ENDNODE;
            fdtsp_pkg::TOKEN_PROP:    cls = fdtsp_pkg::CLS_PROP;
            fdtsp_pkg::TOKEN_NOP:     cls = fdtsp_pkg::CLS_NOP;
            fdtsp_pkg::TOKEN_END:     cls = fdtsp_pkg::CLS_END;
            default:                  cls = fdtsp_pkg::CLS_UNKNOWN;
        endcase
    end

    assign words.ready = !q_full;

    always_comb
    begin
        push.valid          = words.valid && !q_full;
        push.data.word      = words.word;
        push.data.cls       = cls;
        push.data.zero_byte = (words.word[31:24] == 8'h00) || (words.word[23:16] == 8'h00) ||
                              (words.word[15:8] == 8'h00)  || (words.word[7:0] == 8'h00);
        // round the byte length up to whole words
        push.data.len_words = {1'b0, words.word[fdtsp_pkg::WORD_W-1:2]}
                              + fdtsp_pkg::LEFT_W'(words.word[1:0] != 2'b00);
    end

endmodule

@@ design/fdtsp_queue.sv @@
// Short queue of predecoded words between the front end and the sequencer.
module fdtsp_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  fdtsp_pkg::push_t    push,
    output logic                full,
    output logic                q_valid,
    output fdtsp_pkg::pre_t     q_data,
    input  logic                pop
);

    localparam int PTR_W = (fdtsp_pkg::QDEPTH > 1) ? $clog2(fdtsp_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(fdtsp_pkg::QDEPTH + 1);

    fdtsp_pkg::pre_t  entry_reg [fdtsp_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(fdtsp_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fdtsp_pkg::QDEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fdtsp_pkg::QDEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

@@ design/fdtsp_back.sv @@
// Back end: phase sequencer, depth and error tracking, and the result register.
module fdtsp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  fdtsp_pkg::pre_t     q_data,
    output logic                pop,
    fdtsp_result_if.source      results
);

    localparam logic [2:0] PH_TOKEN   = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_NAMEOFF = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    localparam logic [fdtsp_pkg::DEPTH_W-1:0] DEPTH_MAX =
        fdtsp_pkg::DEPTH_W'(fdtsp_pkg::MAX_DEPTH);

    logic [2:0]                      phase_reg, phase_next;
    logic [fdtsp_pkg::LEFT_W-1:0]    left_reg, left_next;
    logic [fdtsp_pkg::DEPTH_W-1:0]   depth_reg, depth_next;
    fdtsp_pkg::err_t                 err_reg, err_next;
    fdtsp_pkg::kind_t                kind;

    logic                            out_valid_reg;
    fdtsp_pkg::kind_t                out_kind_reg;
    logic [fdtsp_pkg::DEPTH_W-1:0]   out_depth_reg;
    logic [fdtsp_pkg::WORD_W-1:0]    out_value_reg;
    fdtsp_pkg::err_t                 out_err_reg;

    assign pop = q_valid && (!out_valid_reg || results.ready);

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        depth_next = depth_reg;
        err_next   = err_reg;
        kind       = fdtsp_pkg::K_ERROR;
        if (err_reg == fdtsp_pkg::E_NONE)
        begin
            unique case (phase_reg)
                PH_NAME:
                begin
                    if (q_data.zero_byte)
                    begin
                        phase_next = PH_TOKEN;
                    end
                    kind = fdtsp_pkg::K_NAME;
                end
                PH_LEN:
                begin
                    left_next  = q_data.len_words;
                    phase_next = PH_NAMEOFF;
                    kind       = fdtsp_pkg::K_LEN;
                end
                PH_NAMEOFF:
                begin
                    phase_next = (left_reg != '0) ? PH_VALUE : PH_TOKEN;
                    kind       = fdtsp_pkg::K_NAMEOFF;
                end
                PH_VALUE:
                begin
                    left_next = left_reg - 1'b1;
                    if (left_reg == fdtsp_pkg::LEFT_W'(1))
                    begin
                        phase_next = PH_TOKEN;
                    end
                    kind = fdtsp_pkg::K_VALUE;
                end
                PH_DONE:
                begin
                    err_next = fdtsp_pkg::E_AFTER_END;
                end
                default:
                begin
                    unique case (q_data.cls)
                        fdtsp_pkg::CLS_BEGIN:
                        begin
                            if (depth_reg >= DEPTH_MAX)
                            begin
                                err_next = fdtsp_pkg::E_DEPTH;
                            end
                            else
                            begin
                                depth_next = depth_reg + 1'b1;
                                phase_next = PH_NAME;
                                kind       = fdtsp_pkg::K_BEGIN;
                            end
                        end
                        fdtsp_pkg::CLS_ENDNODE:
                        begin
                            if (depth_reg == '0)
                            begin
                                err_next = fdtsp_pkg::E_STRUCT;
                            end
                            else
                            begin
                                depth_next = depth_reg - 1'b1;
                                kind       = fdtsp_pkg::K_ENDNODE;
                            end
                        end
                        fdtsp_pkg::CLS_PROP:
                        begin
                            phase_next = PH_LEN;
                            kind       = fdtsp_pkg::K_PROP;
                        end
                        fdtsp_pkg::CLS_NOP:
                        begin
                            kind = fdtsp_pkg::K_NOP;
                        end
                        fdtsp_pkg::CLS_END:
                        begin
                            if (depth_reg != '0)
                            begin
                                err_next = fdtsp_pkg::E_STRUCT;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                kind       = fdtsp_pkg::K_END;
                            end
                        end
                        default:
                        begin
                            err_next = fdtsp_pkg::E_UNKNOWN;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TOKEN;
            left_reg      <= '0;
            depth_reg     <= '0;
            err_reg       <= fdtsp_pkg::E_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                left_reg      <= left_next;
                depth_reg     <= depth_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result word while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_kind_reg  <= kind;
            out_depth_reg <= depth_next;
            out_value_reg <= q_data.word;
            out_err_reg   <= (kind == fdtsp_pkg::K_ERROR) ? err_next : fdtsp_pkg::E_NONE;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = out_kind_reg;
    assign results.depth       = out_depth_reg;
    assign results.field_value = out_value_reg;
    assign results.error_code  = out_err_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("nesting depth above limit");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != fdtsp_pkg::E_NONE) |=> (err_reg == $past(err_reg)))
        else $error("sticky error changed");

    a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VALUE) |-> (left_reg != '0))
        else $error("value phase with no words left");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != fdtsp_pkg::K_ERROR))
            |-> (out_err_reg == fdtsp_pkg::E_NONE))
        else $error("error code on a non-error word");
`endif

endmodule

@@ sim/fdtsp_label_checker.sv @@
// Channel monitor that predicts the label of every structure-block word and checks results in order.
module fdtsp_label_checker
    import fdtsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    fdtsp_word_if   words,
    fdtsp_result_if results,
    output int      fail_count,
    output int      labels_checked,
    output int      error_labels,
    output int      deepest
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SCAN_TOKEN,
        SCAN_NAME,
        SCAN_LEN,
        SCAN_NAMEOFF,
        SCAN_VALUE,
        SCAN_DONE
    } scan_t;

    typedef struct packed {
        kind_t               kind;
        logic [DEPTH_W-1:0]  depth;
        logic [WORD_W-1:0]   field_value;
        err_t                error_code;
    } label_t;

    scan_t              scan_phase;
    logic [LEFT_W-1:0]  value_left;
    logic [DEPTH_W-1:0] tree_depth;
    err_t               held_error;
    label_t             expected_labels[$];

    // Advance the parse state by one word and return the label it earns.
    function automatic label_t label_word(input logic [WORD_W-1:0] w);
        label_t lab;
        kind_t  k;
        if (held_error != E_NONE) begin
            k = K_ERROR;
        end
        else begin
            case (scan_phase)
                SCAN_NAME:
                begin
                    if (w[31:24] == 8'h00 || w[23:16] == 8'h00 ||
                        w[15:8] == 8'h00 || w[7:0] == 8'h00)
                        scan_phase = SCAN_TOKEN;
                    k = K_NAME;
                end
                SCAN_LEN:
                begin
                    // round the byte length up to whole words
                    value_left = LEFT_W'(w >> 2) + LEFT_W'(w[1:0] != 2'b00);
                    scan_phase = SCAN_NAMEOFF;
                    k = K_LEN;
                end
                SCAN_NAMEOFF:
                begin
                    scan_phase = (value_left != '0) ? SCAN_VALUE : SCAN_TOKEN;
                    k = K_NAMEOFF;
                end
                SCAN_VALUE:
                begin
                    value_left = value_left - 1'b1;
                    if (value_left == '0)
                        scan_phase = SCAN_TOKEN;
                    k = K_VALUE;
                end
                SCAN_DONE:
                begin
                    held_error = E_AFTER_END;
                    k = K_ERROR;
                end
                default:
                begin
                    case (w)
                        TOKEN_BEGIN:
                        begin
                            if (tree_depth >= MAX_DEPTH) begin
                                held_error = E_DEPTH;
                                k = K_ERROR;
                            end
                            else begin
                                tree_depth = tree_depth + 1'b1;
                                scan_phase = SCAN_NAME;
                                k = K_BEGIN;
                            end
                        end
                        TOKEN_ENDNODE:
                        begin
                            if (tree_depth == '0) begin
                                held_error = E_STRUCT;
                                k = K_ERROR;
                            end
                            else begin
                                tree_depth = tree_depth - 1'b1;
                                k = K_ENDNODE;
                            end
                        end
                        TOKEN_PROP:
                        begin
                            scan_phase = SCAN_LEN;
                            k = K_PROP;
                        end
                        TOKEN_NOP:
                        begin
                            k = K_NOP;
                        end
                        TOKEN_END:
                        begin
                            if (tree_depth != '0) begin
                                held_error = E_STRUCT;
                                k = K_ERROR;
                            end
                            else begin
                                scan_phase = SCAN_DONE;
                                k = K_END;
                            end
                        end
                        default:
                        begin
                            held_error = E_UNKNOWN;
                            k = K_ERROR;
                        end
                    endcase
                end
            endcase
        end
        lab.kind        = k;
        lab.depth       = tree_depth;
        lab.field_value = w;
        lab.error_code  = (k == K_ERROR) ? held_error : E_NONE;
        return lab;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        label_t want;
        if (!rst_n) begin
            scan_phase = SCAN_TOKEN;
            value_left = '0;
            tree_depth = '0;
            held_error = E_NONE;
            expected_labels.delete();
        end
        else begin
            // pop before push: a result never belongs to the word taken at the same edge
            if (results.valid && results.ready) begin
                if (expected_labels.size() == 0) begin
                    $error("result word 0x%0h arrived with no input word pending",
                           results.field_value);
                    fail_count++;
                end
                else begin
                    want = expected_labels.pop_front();
                    check_field("kind", want.kind, results.kind);
                    check_field("depth", want.depth, results.depth);
                    check_field("field_value", want.field_value, results.field_value);
                    check_field("error_code", want.error_code, results.error_code);
                    labels_checked++;
                    if (want.kind == K_ERROR)
                        error_labels++;
                end
            end
            if (words.valid && words.ready) begin
                expected_labels.push_back(label_word(words.word));
                if (int'(tree_depth) > deepest)
                    deepest = tree_depth;
            end
        end
    end

endmodule

@@ sim/tb_fdt_structure_token_parser.sv @@
// Top of the token parser testbench: clock, reset, word stimulus, result back-pressure, verdict.
module tb_fdt_structure_token_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import fdtsp_pkg::*;

    localparam int HOLD_OFF     = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_WORDS  = 370;

    typedef enum int {
        TAIL_UNKNOWN,
        TAIL_CLOSE_AT_ROOT,
        TAIL_END_WHILE_OPEN,
        TAIL_OVERFLOW,
        TAIL_AFTER_END,
        TAIL_HUGE_LENGTH
    } tail_t;

    logic clk = 1'b0;
    logic rst_n;

    fdtsp_word_if   words_ch();
    fdtsp_result_if results_ch();

    int    fail_count;
    int    labels_checked;
    int    error_labels;
    int    deepest;
    int    words_sent;
    int    gen_depth;
    int    idle_pct;
    int    stall_pct;
    int    hold_cycles;
    tail_t tail_case;

    fdt_structure_token_parser dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (words_ch),
        .results (results_ch)
    );

    fdtsp_label_checker chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .words          (words_ch),
        .results        (results_ch),
        .fail_count     (fail_count),
        .labels_checked (labels_checked),
        .error_labels   (error_labels),
        .deepest        (deepest)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Offer one word, idling first at the current rate, and return at the accepting edge.
    task automatic push_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(0, 99) < idle_pct) begin
            words_ch.valid <= 1'b0;
            @(posedge clk);
        end
        words_ch.valid <= 1'b1;
        words_ch.word  <= w;
        @(posedge clk);
        while (!words_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic open_node();
        logic [WORD_W-1:0] w;
        int                plain;
        push_word(TOKEN_BEGIN);
        plain = $urandom_range(0, 3);
        repeat (plain)
            push_word({8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))});
        // terminate the name: clear one byte, sometimes more
        w = $urandom;
        w[8 * $urandom_range(0, 3) +: 8] = 8'h00;
        push_word(w);
        gen_depth++;
    endtask

    task automatic close_node();
        push_word(TOKEN_ENDNODE);
        gen_depth--;
    endtask

    task automatic add_prop();
        int len;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            len = $urandom_range(0, 8);
        else if (roll < 95)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(41, 128);
        push_word(TOKEN_PROP);
        push_word(len);
        push_word($urandom);
        repeat ((len + 3) / 4)
            push_word($urandom);
    endtask

    task automatic random_element();
        int roll;
        int open_pct;
        roll     = $urandom_range(0, 99);
        open_pct = (gen_depth > 6) ? 12 : 30;
        if (roll < open_pct && gen_depth < MAX_DEPTH)
            open_node();
        else if (roll < 55 && gen_depth > 0)
            close_node();
        else if (roll < 90)
            add_prop();
        else
            push_word(TOKEN_NOP);
    endtask

    task automatic close_all();
        while (gen_depth > 0)
            close_node();
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        results_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                results_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                results_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Stop a hung run: count cycles in which neither channel moves a word.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((words_ch.valid && words_ch.ready) || (results_ch.valid && results_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("fdt_structure_token_parser regression: fail");
        $finish;
    end

    initial
    begin
        int                target;
        logic [WORD_W-1:0] w;
        rst_n          <= 1'b0;
        words_ch.valid <= 1'b0;
        words_ch.word  <= '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        words_sent  = 0;
        gen_depth   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty root name, zero byte in several name positions, zero-length
        // and partial-word properties, nop, nesting back to the root.
        push_word(TOKEN_BEGIN);
        push_word(32'h0000_0000);
        push_word(TOKEN_BEGIN);
        push_word(32'h6370_7573);
        push_word(32'h4100_4243);
        push_word(TOKEN_PROP);
        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word(TOKEN_PROP);
        push_word(32'h0000_0001);
        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word(TOKEN_PROP);
        push_word(32'h0000_0005);
        push_word(32'h0000_0008);
        push_word(32'h0000_0000);
        push_word(32'hDEAD_BEEF);
        push_word(TOKEN_NOP);
        push_word(TOKEN_BEGIN);
        push_word(32'h4142_0043);
        push_word(TOKEN_ENDNODE);
        push_word(TOKEN_ENDNODE);
        push_word(TOKEN_ENDNODE);
        push_word(TOKEN_NOP);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:
                begin
                    idle_pct    = 0;
                    stall_pct   = 0;
                    hold_cycles = HOLD_OFF;
                end
                1:
                begin
                    idle_pct  = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 74;
                end
                default:
                begin
                    idle_pct  = 16;
                    stall_pct = 16;
                end
            endcase
            target = words_sent + PHASE_WORDS;
            if (p == 1) begin
                // dive to the deepest legal nesting and climb back out
                while (gen_depth < MAX_DEPTH) begin
                    open_node();
                    if ($urandom_range(0, 3) == 0)
                        add_prop();
                end
                close_all();
            end
            while (words_sent < target)
                random_element();
        end

        // Close with one broken or unusual stream, then words that hit the stored state.
        tail_case = tail_t'($urandom_range(0, 5));
        case (tail_case)
            TAIL_UNKNOWN:
            begin
                do
                    w = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom;
                while (w == TOKEN_BEGIN || w == TOKEN_ENDNODE || w == TOKEN_PROP ||
                       w == TOKEN_NOP || w == TOKEN_END);
                push_word(w);
            end
            TAIL_CLOSE_AT_ROOT:
            begin
                close_all();
                push_word(TOKEN_ENDNODE);
            end
            TAIL_END_WHILE_OPEN:
            begin
                if (gen_depth == 0)
                    open_node();
                push_word(TOKEN_END);
            end
            TAIL_OVERFLOW:
            begin
                while (gen_depth < MAX_DEPTH)
                    open_node();
                push_word(TOKEN_BEGIN);
            end
            TAIL_AFTER_END:
            begin
                close_all();
                push_word(TOKEN_END);
                push_word(TOKEN_NOP);
            end
            default:
            begin
                push_word(TOKEN_PROP);
                push_word(32'hFFFF_FFFF);
                push_word($urandom);
            end
        endcase
        repeat (8)
            push_word($urandom);
        repeat (8)
            push_word($urandom_range(0, 15));
        words_ch.valid <= 1'b0;

        while (labels_checked < words_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words labeled over four idle and stall mixes, nesting up to %0d",
                 words_sent, deepest);
        $display("closing stream %s produced %0d error words", tail_case.name(),
                 error_labels);
        if (fail_count == 0)
            $display("fdt_structure_token_parser regression: pass");
        else
            $display("fdt_structure_token_parser regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
design/fdtsp_pkg.sv
design/fdtsp_if.sv
design/fdtsp_front.sv
design/fdtsp_queue.sv
design/fdtsp_back.sv
design/fdt_structure_token_parser.sv
sim/fdtsp_label_checker.sv
sim/tb_fdt_structure_token_parser.sv
